>>> hdl/assert_macros.svh
// Assertion helper macros shared by the RTL of the frame allocator.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fba_pkg.sv
// Package of the frame bitmap allocator: sizes, request and status codes,
// state encoding and the bit-mask and encoder helpers. No dependencies.
package fba_pkg;

    localparam int unsigned FRAME_WORDS = 256;
    localparam int unsigned PAGE_BYTES  = 4096;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned BITS_W      = 64;
    localparam int unsigned BIT_IDX_W   = 6;
    localparam int unsigned PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int unsigned WORD_W      = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int unsigned HI_W        = ADDR_W - PAGE_SHIFT - BIT_IDX_W;

    // First-free search: words grouped by sixteen, then groups resolved.
    localparam int unsigned GRP_SIZE    = 16;
    localparam int unsigned GRP_IDX_W   = 4;
    localparam int unsigned NGRP        = (FRAME_WORDS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int unsigned GRP_W       = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int unsigned GPAD        = NGRP * GRP_SIZE;

    // Frames below 1 MiB are reserved at reset.
    localparam longint unsigned LOW_RESERVED = 64'h0010_0000;
    localparam longint unsigned LOW_FRAMES   = LOW_RESERVED / PAGE_BYTES;
    localparam int unsigned LOW_LIM_W        = 32'(LOW_FRAMES / BITS_W);
    localparam int unsigned LOW_LIM_B        = 32'(LOW_FRAMES % BITS_W);

    // Frames whose byte address fits in 32 bits.
    localparam longint unsigned REACH_FRAMES = 64'h1_0000_0000 / PAGE_BYTES;
    localparam int unsigned REACH_LIM_W      = 32'(REACH_FRAMES / BITS_W);
    localparam int unsigned REACH_LIM_B      = 32'(REACH_FRAMES % BITS_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_MARK  = 2'd2,
        MODE_TEST  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND1,
        ST_FIND2,
        ST_READ,
        ST_MOD
    } state_t;

    // Bits of word w whose frame number lies below lim_w * 64 + lim_b.
    function automatic logic [BITS_W-1:0] below_mask(logic [WORD_W-1:0] w,
                                                     int unsigned lim_w,
                                                     int unsigned lim_b);
        logic [BITS_W-1:0] m;
        if (32'(w) < lim_w) begin
            m = '1;
        end else if (32'(w) == lim_w) begin
            m = (BITS_W'(1) << lim_b) - BITS_W'(1);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    function automatic logic [BITS_W-1:0] reset_word(logic [WORD_W-1:0] w);
        return below_mask(w, LOW_LIM_W, LOW_LIM_B);
    endfunction

    function automatic logic [BITS_W-1:0] reach_mask(logic [WORD_W-1:0] w);
        return below_mask(w, REACH_LIM_W, REACH_LIM_B);
    endfunction

    // Encoders take a one-hot (or zero) vector.
    function automatic logic [BIT_IDX_W-1:0] enc_word(logic [BITS_W-1:0] v);
        logic [BIT_IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < BITS_W; i++) begin
            if (v[i]) begin
                r = r | BIT_IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [GRP_IDX_W-1:0] enc_grp(logic [GRP_SIZE-1:0] v);
        logic [GRP_IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < GRP_SIZE; i++) begin
            if (v[i]) begin
                r = r | GRP_IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [GRP_W-1:0] enc_grps(logic [NGRP-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = 0; i < NGRP; i++) begin
            if (v[i]) begin
                r = r | GRP_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/frame_bitmap_allocator_unit.sv
// An allocate steps through FIND1, FIND2, READ and MOD (FIND2 goes straight to MOD when no
// frame is free), free/mark/test through READ and MOD, out of range straight to MOD; MOD
// waits while the result register holds a stalled result. Each request is finished before
// the next is taken; the first-free search is two-level and the bitmap read is registered.
// Reset (rst_n, async, active low) clears per-word valid flags at once: unwritten words
// read as their reset contents (low 1 MiB used), so there is no clearing pass.
`include "assert_macros.svh"

module frame_bitmap_allocator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [fba_pkg::MODE_W-1:0]      mode,
    input  logic [fba_pkg::ADDR_W-1:0]      addr,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [fba_pkg::ADDR_W-1:0]      result_addr,
    output logic                            used,
    output logic [fba_pkg::STATUS_W-1:0]    status
);
    import fba_pkg::*;

    // The bitmap itself: one 64-bit word per 64 frames, 1 means used.
    logic [BITS_W-1:0] mem [FRAME_WORDS];

    // Per-word flags. A word that was never written reads as its reset value.
    // The summary holds one bit per word: the word still has a reachable free frame.
    logic [FRAME_WORDS-1:0] valid_reg;
    logic [FRAME_WORDS-1:0] has_free_reg;

    state_t state_reg, state_next;

    // Request held while it is worked on.
    mode_t                  mode_reg;
    logic [WORD_W-1:0]      word_reg;
    logic [BIT_IDX_W-1:0]   bit_reg;
    logic                   range_err_reg;
    logic                   full_reg;

    // Registered memory read.
    logic [BITS_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;

    // First search stage: lowest word with free frames inside each group.
    logic [NGRP-1:0]        grp_any_reg;
    logic [GRP_IDX_W-1:0]   grp_idx_reg [NGRP];

    // Result register, which decouples the response side from the work.
    logic                   rsp_valid_reg;
    logic [ADDR_W-1:0]      result_addr_reg;
    logic                   used_reg;
    status_t                status_reg;

    // Control decoded from the state.
    logic accept;
    logic load;
    logic rd_en;
    logic mem_we;
    logic in_mod;
    logic alloc_step;

    // Address decomposition of the incoming request.
    logic [HI_W-1:0]        addr_hi;
    logic                   addr_in_range;

    // Search and modify datapath.
    logic [GPAD-1:0]        hf_pad;
    logic [NGRP-1:0]        grp_low;
    logic [GRP_W-1:0]       grp_sel;
    logic [WORD_W-1:0]      word_found;
    logic [BITS_W-1:0]      cur_word;
    logic [BITS_W-1:0]      alloc_free;
    logic [BITS_W-1:0]      alloc_hot;
    logic [BIT_IDX_W-1:0]   alloc_bit;
    logic [BITS_W-1:0]      bit_hot;
    logic [BITS_W-1:0]      new_word;
    logic [ADDR_W-1:0]      res_addr_c;
    logic                   used_c;
    status_t                status_c;

    assign addr_hi       = addr[ADDR_W-1 -: HI_W];
    assign addr_in_range = 32'(addr_hi) < 32'(FRAME_WORDS);

    // ------------------------------------------------------------------
    // Sequencer. Only one request is in the datapath at a time; a new one
    // is taken while the previous result still waits in the result register.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid) begin
                    if (mode_t'(mode) == MODE_ALLOC) begin
                        state_next = ST_FIND1;
                    end else if (!addr_in_range) begin
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_FIND1:
            begin
                state_next = ST_FIND2;
            end
            ST_FIND2:
            begin
                state_next = (grp_any_reg != '0) ? ST_READ : ST_MOD;
            end
            ST_READ:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (!rsp_valid_reg || !rsp_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        load      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_READ:
            begin
                rd_en = 1'b1;
            end
            ST_MOD:
            begin
                load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept     = req_valid && !req_stall;
    assign mem_we     = load && !range_err_reg && !full_reg && (mode_reg != MODE_TEST);
    assign in_mod     = (state_reg == ST_MOD);
    assign alloc_step = in_mod && (mode_reg == MODE_ALLOC) && !full_reg && !range_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // First-free search over the summary vector, two registered levels.
    // ------------------------------------------------------------------
    assign hf_pad = GPAD'(has_free_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIND1) begin
            for (int g = 0; g < NGRP; g++) begin
                grp_any_reg[g] <= |hf_pad[g*GRP_SIZE +: GRP_SIZE];
                grp_idx_reg[g] <= enc_grp(hf_pad[g*GRP_SIZE +: GRP_SIZE]
                                          & (~hf_pad[g*GRP_SIZE +: GRP_SIZE]
                                             + GRP_SIZE'(1)));
            end
        end
    end

    assign grp_low    = grp_any_reg & (~grp_any_reg + NGRP'(1));
    assign grp_sel    = enc_grps(grp_low);
    assign word_found = WORD_W'({grp_sel, grp_idx_reg[grp_sel]});

    // ------------------------------------------------------------------
    // Request registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            range_err_reg <= 1'b0;
            full_reg      <= 1'b0;
        end else if (accept) begin
            range_err_reg <= (mode_t'(mode) != MODE_ALLOC) && !addr_in_range;
            full_reg      <= 1'b0;
        end else if (state_reg == ST_FIND2) begin
            full_reg      <= (grp_any_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            mode_reg <= mode_t'(mode);
            word_reg <= WORD_W'(addr_hi);
            bit_reg  <= addr[PAGE_SHIFT +: BIT_IDX_W];
        end else if (state_reg == ST_FIND2) begin
            word_reg <= word_found;
        end
    end

    // ------------------------------------------------------------------
    // Bitmap memory: one write port and one registered read port. Reads and
    // writes never overlap, since the write happens only in the last state.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[word_reg] <= new_word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[word_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_valid_reg <= 1'b0;
        end else if (rd_en) begin
            rd_valid_reg <= valid_reg[word_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            for (int w = 0; w < FRAME_WORDS; w++) begin
                has_free_reg[w] <= |(~reset_word(WORD_W'(w)) & reach_mask(WORD_W'(w)));
            end
        end else if (mem_we) begin
            valid_reg[word_reg]    <= 1'b1;
            has_free_reg[word_reg] <= |(~new_word & reach_mask(word_reg));
        end
    end

    // ------------------------------------------------------------------
    // Modify step: pick the bit, build the new word and the response.
    // ------------------------------------------------------------------
    assign cur_word   = rd_valid_reg ? rd_data_reg : reset_word(word_reg);
    assign alloc_free = ~cur_word & reach_mask(word_reg);
    assign alloc_hot  = alloc_free & (~alloc_free + BITS_W'(1));
    assign alloc_bit  = enc_word(alloc_hot);
    assign bit_hot    = BITS_W'(1) << bit_reg;

    always_comb
    begin
        new_word   = cur_word;
        res_addr_c = '0;
        used_c     = 1'b0;
        status_c   = STAT_OK;
        priority if (range_err_reg) begin
            status_c = STAT_RANGE;
        end else if (full_reg) begin
            status_c = STAT_FULL;
        end else begin
            unique case (mode_reg)
                MODE_ALLOC:
                begin
                    new_word   = cur_word | alloc_hot;
                    res_addr_c = ADDR_W'({word_reg, alloc_bit, {PAGE_SHIFT{1'b0}}});
                end
                MODE_FREE:
                begin
                    new_word = cur_word & ~bit_hot;
                end
                MODE_MARK:
                begin
                    new_word = cur_word | bit_hot;
                end
                MODE_TEST:
                begin
                    used_c = cur_word[bit_reg];
                end
                default:
                begin
                    new_word = cur_word;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_valid_reg <= 1'b0;
        end else if (load) begin
            rsp_valid_reg <= 1'b1;
        end else if (!rsp_stall) begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            result_addr_reg <= res_addr_c;
            used_reg        <= used_c;
            status_reg      <= status_c;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign result_addr = result_addr_reg;
    assign used        = used_reg;
    assign status      = STATUS_W'(status_reg);

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `ASSERT_IMPLY(a_full_summary, in_mod && full_reg, has_free_reg == '0, "full with free words")
    `ASSERT_IMPLY(a_alloc_hit, alloc_step, alloc_free != '0, "summary hit a full word")
    `ASSERT_IMPLY(a_write_state, mem_we, in_mod && !rd_en, "bitmap written outside modify")
    `ASSERT_NEXT(a_load_valid, load, rsp_valid_reg && (state_reg == ST_IDLE), "result lost")

endmodule

>>> tb/tb.sv
// Self-checking testbench of frame_bitmap_allocator_unit: directed, random and
// backpressure requests are checked against an in-bench bitmap predictor.
// Depends on fba_pkg and the frame_bitmap_allocator_unit RTL.
module tb;
    import fba_pkg::*;

    // Frames covered by the bitmap, and the run limits.
    localparam int unsigned     MAP_FRAMES   = FRAME_WORDS * 64;
    localparam longint unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned     DRAIN_CYCLES = 12;

    // One expected result: the three output fields of the block.
    typedef struct {
        logic [ADDR_W-1:0] exp_addr;
        logic              used;
        status_t           status;
    } frame_rsp_t;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   addr;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [ADDR_W-1:0]   result_addr;
    logic                used;
    logic [STATUS_W-1:0] status;

    // Predicted bitmap: one bit per frame, 1 means the frame is in use.
    logic [63:0]     frame_map [FRAME_WORDS];
    // Results of accepted requests that have not come back yet, oldest first.
    frame_rsp_t      pending_rsp [$];
    int unsigned     tx_idle_pct = 0;
    int unsigned     rx_stall_pct = 0;
    int unsigned     rsp_hold_left = 0;
    int unsigned     mismatch_count = 0;
    longint unsigned cycle_count = 0;

    frame_bitmap_allocator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .mode        (mode),
        .addr        (addr),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .result_addr (result_addr),
        .used        (used),
        .status      (status)
    );

    initial
    begin : clock_gen
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // After reset every frame that holds an address below 1 MiB is in use.
    function automatic void reset_frame_map();
        longint unsigned f;
        foreach (frame_map[w])
        begin
            frame_map[w] = '0;
        end
        for (f = 0; f * PAGE_BYTES < 64'h10_0000; f++)
        begin
            if (f < MAP_FRAMES)
            begin
                frame_map[f / 64][f % 64] = 1'b1;
            end
        end
    endfunction

    // Applies one request to the predicted bitmap and returns the result it gives.
    function automatic frame_rsp_t apply_frame_request(mode_t m, logic [ADDR_W-1:0] a);
        frame_rsp_t      r;
        longint unsigned frame;
        longint unsigned word;
        longint unsigned bpos;
        bit              found;
        r.exp_addr = '0;
        r.used     = 1'b0;
        r.status   = STAT_OK;
        found      = 1'b0;
        frame      = 0;
        if (m == MODE_ALLOC)
        begin
            // Lowest clear bit wins; full words are skipped whole.
            for (word = 0; word < FRAME_WORDS && !found; word++)
            begin
                if (frame_map[word] != '1)
                begin
                    for (bpos = 0; bpos < 64 && !found; bpos++)
                    begin
                        if (!frame_map[word][bpos])
                        begin
                            frame = word * 64 + bpos;
                            found = 1'b1;
                        end
                    end
                end
            end
            // A frame whose address does not fit in 32 bits cannot be handed out.
            if (found && frame * PAGE_BYTES <= 64'hFFFF_FFFF)
            begin
                frame_map[frame / 64][frame % 64] = 1'b1;
                r.exp_addr = ADDR_W'(frame * PAGE_BYTES);
            end
            else
            begin
                r.status = STAT_FULL;
            end
        end
        else
        begin
            frame = {32'b0, a} / PAGE_BYTES;
            word  = frame / 64;
            bpos  = frame % 64;
            if (word >= FRAME_WORDS)
            begin
                r.status = STAT_RANGE;
            end
            else
            begin
                case (m)
                    MODE_FREE: frame_map[word][bpos] = 1'b0;
                    MODE_MARK: frame_map[word][bpos] = 1'b1;
                    default:   r.used = frame_map[word][bpos];
                endcase
            end
        end
        return r;
    endfunction

    // A byte address somewhere inside the given frame.
    function automatic logic [ADDR_W-1:0] addr_in_frame(int unsigned f);
        return ADDR_W'(f * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1));
    endfunction

    // Most addresses fall near the low end of free memory, where allocations land,
    // so that free, mark and test requests hit frames that allocations care about.
    function automatic logic [ADDR_W-1:0] pick_addr();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
        begin
            return addr_in_frame($urandom_range(639));
        end
        if (sel < 88)
        begin
            return addr_in_frame($urandom_range(MAP_FRAMES - 1));
        end
        if (sel < 95)
        begin
            return $urandom_range(32'hFFFF_FFFF, MAP_FRAMES * PAGE_BYTES);
        end
        return $urandom;
    endfunction

    // Allocations outnumber frees so the low end of free memory keeps moving up.
    function automatic mode_t pick_mode();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            return MODE_ALLOC;
        end
        if (sel < 60)
        begin
            return MODE_FREE;
        end
        if (sel < 75)
        begin
            return MODE_MARK;
        end
        return MODE_TEST;
    endfunction

    function automatic void report_mismatch(string field, logic [ADDR_W-1:0] want,
                                            logic [ADDR_W-1:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // Offers one request, holding it steady while stalled. Valid is only dropped for a
    // random idle gap, so back-to-back requests keep valid high without a glitch.
    // Called and returns at a rising edge; on return the request has just been accepted.
    task automatic send_req(input mode_t m, input logic [ADDR_W-1:0] a);
        frame_rsp_t want;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        mode      <= m;
        addr      <= a;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        want = apply_frame_request(m, a);
        pending_rsp.push_back(want);
    endtask

    // Basic behavior: reserved low memory, the allocation order, freeing frame zero and
    // getting it back as address zero, repeated free and mark, the last frame, and
    // addresses past the end of memory including the all-ones address.
    task automatic test_directed();
        send_req(MODE_TEST, 32'h0000_0000);
        send_req(MODE_TEST, 32'h000F_FFFF);
        send_req(MODE_TEST, 32'h0010_0000);
        send_req(MODE_ALLOC, 32'h0000_0000);
        send_req(MODE_ALLOC, 32'hFFFF_FFFF);
        send_req(MODE_TEST, 32'h0010_0000);
        send_req(MODE_FREE, 32'h0010_0FFF);
        send_req(MODE_FREE, 32'h0010_0FFF);
        send_req(MODE_TEST, 32'h0010_0000);
        send_req(MODE_ALLOC, 32'h5555_5555);
        send_req(MODE_FREE, 32'h0000_0000);
        send_req(MODE_ALLOC, 32'hAAAA_AAAA);
        send_req(MODE_MARK, 32'h03FF_FFFF);
        send_req(MODE_MARK, 32'h03FF_F000);
        send_req(MODE_TEST, 32'h03FF_F123);
        send_req(MODE_FREE, 32'h03FF_F000);
        send_req(MODE_TEST, 32'h03FF_F000);
        send_req(MODE_MARK, 32'h0010_2000);
        send_req(MODE_ALLOC, 32'h0000_0000);
        send_req(MODE_FREE, 32'h0400_0000);
        send_req(MODE_MARK, 32'hFFFF_FFFF);
        send_req(MODE_TEST, 32'h8000_0000);
        send_req(MODE_TEST, 32'h0400_0000);
    endtask

    task automatic test_random_mix(input int unsigned count, input int unsigned tx_pct,
                                   input int unsigned rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count)
        begin
            send_req(pick_mode(), pick_addr());
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming, so the
    // unit fills up and has to stall its request side.
    task automatic test_backpressure();
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        rsp_hold_left = 300;
        repeat (24)
        begin
            send_req(pick_mode(), pick_addr());
        end
    endtask

    // Result side: checks each accepted result against the oldest expectation and
    // decides the stall for the next cycle, honoring a requested hold-off first.
    initial
    begin : rsp_checker
        frame_rsp_t want;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            begin
                if (pending_rsp.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no request outstanding, expected none, got addr %h",
                             $time, result_addr);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (result_addr !== want.exp_addr)
                    begin
                        report_mismatch("result_addr", want.exp_addr, result_addr);
                    end
                    if (used !== want.used)
                    begin
                        report_mismatch("used", ADDR_W'(want.used), ADDR_W'(used));
                    end
                    if (status !== want.status)
                    begin
                        report_mismatch("status", ADDR_W'(want.status), ADDR_W'(status));
                    end
                end
            end
            if (rsp_hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold_left--;
            end
            else
            begin
                rsp_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Ends a run that hangs, for example when a result never comes back.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[frame_bitmap_allocator_unit] ERROR");
        $finish;
    end

    initial
    begin : test_sequence
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        mode      <= MODE_ALLOC;
        addr      <= '0;
        reset_frame_map();
        repeat (3)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // Slow sender with a mostly stalled receiver, then the reverse, then full speed.
        test_random_mix(250, 33, 86);
        test_random_mix(250, 86, 33);
        test_random_mix(250, 0, 0);
        test_backpressure();

        // Wait for the last results, then let the unit run on idle to show any
        // stray result before judging the run.
        req_valid     <= 1'b0;
        rx_stall_pct  = 0;
        while (pending_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0)
        begin
            $display("[frame_bitmap_allocator_unit] OK");
        end
        else
        begin
            $display("[frame_bitmap_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule
